@@ hdl/sacrr_pkg.sv @@
// Shared types, constants and a helper function for the random-replacement cache.
package sacrr_pkg;

    localparam int MaxLines  = 2048;
    localparam int LineBits  = $clog2(MaxLines);
    localparam int AddrWidth = 32;
    localparam int TagBits   = 28;
    localparam int CntBits   = 32;
    localparam int CfgBits   = 4;
    localparam int CfgIdxBits = 2;
    localparam int WayCntBits = LineBits + 1;
    localparam int OutBits   = 80;

    localparam logic [3:0] MinOffset    = 4'd4;
    localparam logic [3:0] MaxLinesLog2 = 4'(LineBits);

    localparam logic [15:0] LfsrTaps = 16'hB400;
    localparam logic [15:0] LfsrSeed = 16'hACE1;

    localparam logic [CfgIdxBits-1:0] CfgOffsetBits = 2'd0;
    localparam logic [CfgIdxBits-1:0] CfgLinesLog2  = 2'd1;
    localparam logic [CfgIdxBits-1:0] CfgWaysLog2   = 2'd2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic clr;
        logic load;
        logic scan;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic hit;
        logic last;
    } t_status;

    function automatic logic [15:0] lfsr_next(input logic [15:0] s);
        logic [15:0] n;
        n = s >> 1;
        if (s[0]) begin
            n = n ^ LfsrTaps;
        end
        return n;
    endfunction

endpackage

@@ hdl/set_assoc_cache_random_replace.sv @@
// Top level of the set-associative cache lookup with random replacement.
//
// Channel   Direction  Contents
// s_axis    in         tdata[31:0] = address
// m_axis    out        tdata[0] = hit, [11:1] = way_used, [43:12] = hit_count,
//                      [75:44] = miss_count, [79:76] = zero
// cfg       in         i_cfg_we, i_cfg_idx (0 offset_bits, 1 lines_log2, 2 ways_log2)
//
// After reset the line memory is cleared one line per cycle;
// no transaction is accepted during that time, configuration writes are.
// A lookup reads one way per cycle from the line memory port; a hit ends the
// scan early. A result waiting in the output register stalls only the final
// update cycle of the next item.
module set_assoc_cache_random_replace
    import sacrr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [AddrWidth-1:0]  s_axis_tdata,   // address
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OutBits-1:0]    m_axis_tdata,   // hit, way_used, hit_count, miss_count
    input  logic                  i_cfg_we,
    input  logic [CfgIdxBits-1:0] i_cfg_idx,
    input  logic [CfgBits-1:0]    i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    sacrr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    sacrr_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_address  (s_axis_tdata),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_data (m_axis_tdata)
    );

endmodule

@@ hdl/sacrr_ctrl.sv @@
// Controller state machine that sequences clearing, lookup and result hand-off.
module sacrr_ctrl
    import sacrr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.hit || i_status.last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_out_valid = o_cmd.finish ? 1'b1 : (r_out_valid && !i_out_ready);
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ hdl/sacrr_dp.sv @@
// Datapath with geometry registers, line memory, way scan, counters and victim LFSR.
module sacrr_dp
    import sacrr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CfgIdxBits-1:0] i_cfg_idx,
    input  logic [CfgBits-1:0]    i_cfg_data,
    input  logic [AddrWidth-1:0]  i_address,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output logic [OutBits-1:0]    o_out_data
);

    logic [2:0] r_offset_bits;
    logic [3:0] r_lines_log2;
    logic [3:0] r_ways_log2;

    logic [TagBits:0]     r_mem [MaxLines];
    logic [TagBits:0]     r_rdata;
    logic [LineBits-1:0]  r_clr_idx;
    logic [WayCntBits-1:0] r_rd_cnt;
    logic                 r_cmp_valid;
    logic [LineBits-1:0]  r_cmp_way;
    logic [LineBits-1:0]  r_base;
    logic [TagBits-1:0]   r_tag;
    logic                 r_hit;
    logic [LineBits-1:0]  r_way;
    logic                 r_free_found;
    logic [LineBits-1:0]  r_free_way;
    logic [CntBits-1:0]   r_hits;
    logic [CntBits-1:0]   r_misses;
    logic [15:0]          r_lfsr;
    logic [OutBits-1:0]   r_out_data;

    logic [3:0]           off;
    logic [3:0]           ll;
    logic [3:0]           wl;
    logic [3:0]           sl;
    logic [AddrWidth-1:0] block;
    logic [AddrWidth-1:0] tag_full;
    logic [LineBits-1:0]  set_mask;
    logic [LineBits-1:0]  way_mask;
    logic [LineBits-1:0]  base;
    logic [WayCntBits-1:0] n_ways;
    logic                 issue;
    logic [LineBits-1:0]  rd_addr;
    logic                 match;
    logic [15:0]          lfsr_nx;
    logic [LineBits-1:0]  sel_way;
    logic                 wr_en;
    logic [LineBits-1:0]  wr_addr;
    logic [TagBits:0]     wr_data;
    logic [CntBits-1:0]   n_hits;
    logic [CntBits-1:0]   n_misses;

    always_comb begin
        off      = (r_offset_bits < 3'(MinOffset)) ? MinOffset : {1'b0, r_offset_bits};
        ll       = (r_lines_log2 > MaxLinesLog2) ? MaxLinesLog2 : r_lines_log2;
        wl       = (r_ways_log2 > ll) ? ll : r_ways_log2;
        sl       = ll - wl;
        block    = i_address >> off;
        tag_full = block >> sl;
        set_mask = LineBits'((WayCntBits'(1) << sl) - WayCntBits'(1));
        way_mask = LineBits'((WayCntBits'(1) << wl) - WayCntBits'(1));
        base     = LineBits'((block[LineBits-1:0] & set_mask) << wl);
        n_ways   = WayCntBits'(1) << wl;
        issue    = i_cmd.scan && (r_rd_cnt < n_ways);
        rd_addr  = r_base + r_rd_cnt[LineBits-1:0];
        match    = r_cmp_valid && r_rdata[TagBits] && (r_rdata[TagBits-1:0] == r_tag);
        lfsr_nx  = lfsr_next(r_lfsr);
        if (r_hit) begin
            sel_way = r_way;
        end else if (r_free_found) begin
            sel_way = r_free_way;
        end else begin
            sel_way = lfsr_nx[LineBits-1:0] & way_mask;
        end
        wr_en    = i_cmd.clr || (i_cmd.finish && !r_hit);
        wr_addr  = i_cmd.clr ? r_clr_idx : (r_base + sel_way);
        wr_data  = i_cmd.clr ? '0 : {1'b1, r_tag};
        n_hits   = (r_hit && (r_hits != '1)) ? (r_hits + CntBits'(1)) : r_hits;
        n_misses = (!r_hit && (r_misses != '1)) ? (r_misses + CntBits'(1)) : r_misses;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (issue) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_bits <= 3'd6;
            r_lines_log2  <= 4'd11;
            r_ways_log2   <= 4'd3;
            r_clr_idx     <= '0;
            r_rd_cnt      <= '0;
            r_cmp_valid   <= 1'b0;
            r_hit         <= 1'b0;
            r_free_found  <= 1'b0;
            r_hits        <= '0;
            r_misses      <= '0;
            r_lfsr        <= LfsrSeed;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CfgOffsetBits) begin
                    r_offset_bits <= i_cfg_data[2:0];
                end else if (i_cfg_idx == CfgLinesLog2) begin
                    r_lines_log2 <= i_cfg_data;
                end else if (i_cfg_idx == CfgWaysLog2) begin
                    r_ways_log2 <= i_cfg_data;
                end
            end
            if (i_cmd.clr) begin
                r_clr_idx <= r_clr_idx + LineBits'(1);
            end
            r_cmp_valid <= issue;
            if (issue) begin
                r_rd_cnt <= r_rd_cnt + WayCntBits'(1);
            end
            if (i_cmd.load) begin
                r_rd_cnt     <= '0;
                r_hit        <= 1'b0;
                r_free_found <= 1'b0;
            end
            if (i_cmd.scan && match) begin
                r_hit <= 1'b1;
            end
            if (i_cmd.scan && r_cmp_valid && !r_rdata[TagBits] && !r_free_found) begin
                r_free_found <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_hits   <= n_hits;
                r_misses <= n_misses;
                if (!r_hit && !r_free_found) begin
                    r_lfsr <= lfsr_nx;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_way <= r_rd_cnt[LineBits-1:0];
        if (i_cmd.load) begin
            r_base <= base;
            r_tag  <= tag_full[TagBits-1:0];
        end
        if (i_cmd.scan && match) begin
            r_way <= r_cmp_way;
        end
        if (i_cmd.scan && r_cmp_valid && !r_rdata[TagBits] && !r_free_found) begin
            r_free_way <= r_cmp_way;
        end
        if (i_cmd.finish) begin
            r_out_data <= {4'b0, n_misses, n_hits, sel_way, r_hit};
        end
    end

    assign o_status.clr_last = &r_clr_idx;
    assign o_status.hit      = match;
    assign o_status.last     = r_cmp_valid && (r_cmp_way == way_mask);
    assign o_out_data        = r_out_data;

endmodule
